// ===== rtl/pvbk_pkg.sv =====
// pvbk_pkg: types, constants and micro-op codes for the position/velocity/bias filter.
// No dependencies.
package pvbk_pkg;

   localparam int VALUE_WIDTH   = 48;
   localparam int FRACTION_BITS = 24;
   localparam int CFG_COUNT     = 7;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam value_type MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type ONE_FX  = value_type'(64'd1 << FRACTION_BITS);

   typedef enum logic [2:0] {
      CFG_POS_NOISE  = 3'd0,
      CFG_VEL_NOISE  = 3'd1,
      CFG_BIAS_NOISE = 3'd2,
      CFG_MEAS_NOISE = 3'd3,
      CFG_OBS_GAIN   = 3'd4,
      CFG_TIME_STEP  = 3'd5,
      CFG_INIT_VAR   = 3'd6
   } cfg_index_type;

   // shared unit operations
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_HALF = 3'd4,
      OP_MOV = 3'd5
   } op_type;

   typedef struct packed {
      value_type  measured_position;
      value_type  acceleration;
      logic       restart;
   } req_type;

   typedef struct packed {
      value_type  position_estimate;
      value_type  velocity_estimate;
      value_type  bias_estimate;
      logic       overflow;
      logic       update_skipped;
   } rsp_type;

   typedef struct packed {
      logic       start;
      op_type     op;
      value_type  a;
      value_type  b;
   } alu_cmd_type;

   typedef struct packed {
      logic       done;
      value_type  result;
      logic       sat;
   } alu_rsp_type;

   // register file slots
   localparam int NSLOT = 32;
   localparam int SW = $clog2(NSLOT);
   typedef logic [SW-1:0] slot_type;

   localparam slot_type S_P0 = 0;   // P[0..8] in slots 0..8
   localparam slot_type S_POS = 9;
   localparam slot_type S_VEL = 10;
   localparam slot_type S_BIAS = 11;
   localparam slot_type S_Z = 12;
   localparam slot_type S_ACC = 13;
   localparam slot_type S_DT = 14;
   localparam slot_type S_C = 15;
   localparam slot_type S_QP = 16;
   localparam slot_type S_QV = 17;
   localparam slot_type S_QB = 18;
   localparam slot_type S_R = 19;
   localparam slot_type S_ZERO = 20;
   localparam slot_type S_T0 = 21;   // temporaries 21..31
   localparam slot_type S_T1 = 22;
   localparam slot_type S_T2 = 23;
   localparam slot_type S_T3 = 24;
   localparam slot_type S_D0 = 25;   // d / k / tv scratch
   localparam slot_type S_D1 = 26;
   localparam slot_type S_D2 = 27;
   localparam slot_type S_D3 = 28;
   localparam slot_type S_D4 = 29;
   localparam slot_type S_D5 = 30;
   localparam slot_type S_D6 = 31;

   typedef struct packed {
      op_type     op;
      slot_type   sa;
      slot_type   sb;
      slot_type   dst;
   } uop_type;

   function automatic slot_type pslot(input int i);
      return slot_type'(i);
   endfunction

   // micro-program
   localparam int PRED_LEN = 64;
   localparam int CORR_LEN = 40;
   localparam int PROG_LEN = PRED_LEN + CORR_LEN;
   localparam int PW = $clog2(PROG_LEN);

   function automatic uop_type mk(input op_type o, input slot_type a, input slot_type b,
                                  input slot_type d);
      uop_type u;
      u.op = o; u.sa = a; u.sb = b; u.dst = d;
      return u;
   endfunction

   // d values need 9 slots; d8 = bias_noise used directly.
   // d0..d6 -> S_D0..S_D6, d7 == d5 (both -p8).
   function automatic uop_type prog_rom(input logic [PW-1:0] pc);
      uop_type u;
      u = mk(OP_MOV, S_ZERO, S_ZERO, S_T0);
      case (pc)
         // prediction of state
         0:  u = mk(OP_SUB, S_ACC, S_BIAS, S_T0);           // e
         1:  u = mk(OP_MUL, S_T0, S_DT, S_T1);              // e*dt
         2:  u = mk(OP_ADD, S_VEL, S_T1, S_VEL);
         3:  u = mk(OP_MUL, S_T1, S_DT, S_T2);
         4:  u = mk(OP_HALF, S_T2, S_ZERO, S_T2);
         5:  u = mk(OP_MUL, S_VEL, S_DT, S_T3);
         6:  u = mk(OP_ADD, S_T2, S_T3, S_T2);
         7:  u = mk(OP_ADD, S_POS, S_T2, S_POS);
         // d0
         8:  u = mk(OP_ADD, S_QP, pslot(1), S_D0);
         9:  u = mk(OP_ADD, S_D0, pslot(3), S_D0);
         10: u = mk(OP_HALF, pslot(6), S_ZERO, S_T0);
         11: u = mk(OP_SUB, pslot(4), S_T0, S_T0);
         12: u = mk(OP_HALF, pslot(2), S_ZERO, S_T1);
         13: u = mk(OP_SUB, S_T0, S_T1, S_T0);
         14: u = mk(OP_MUL, S_T0, S_DT, S_T0);
         15: u = mk(OP_ADD, S_D0, S_T0, S_D0);
         // d1
         16: u = mk(OP_SUB, pslot(4), pslot(2), S_D1);
         17: u = mk(OP_HALF, pslot(7), S_ZERO, S_T0);
         18: u = mk(OP_ADD, S_T0, pslot(5), S_T0);
         19: u = mk(OP_MUL, S_T0, S_DT, S_T0);
         20: u = mk(OP_SUB, S_D1, S_T0, S_D1);
         // half(p8*dt) shared by d2, d6
         21: u = mk(OP_MUL, pslot(8), S_DT, S_T3);          // p8*dt
         22: u = mk(OP_HALF, S_T3, S_ZERO, S_T2);
         23: u = mk(OP_SUB, pslot(5), S_T2, S_D2);
         // d3
         24: u = mk(OP_SUB, pslot(4), pslot(6), S_D3);
         25: u = mk(OP_HALF, pslot(5), S_ZERO, S_T0);
         26: u = mk(OP_ADD, pslot(7), S_T0, S_T0);
         27: u = mk(OP_MUL, S_T0, S_DT, S_T0);
         28: u = mk(OP_SUB, S_D3, S_T0, S_D3);
         // d4
         29: u = mk(OP_SUB, S_QV, pslot(7), S_D4);
         30: u = mk(OP_SUB, S_D4, pslot(5), S_D4);
         31: u = mk(OP_ADD, S_D4, S_T3, S_D4);
         // d5 (=d7), d6
         32: u = mk(OP_SUB, S_ZERO, pslot(8), S_D5);
         33: u = mk(OP_SUB, pslot(7), S_T2, S_D6);
         // P += d*dt
         34: u = mk(OP_MUL, S_D0, S_DT, S_T0);
         35: u = mk(OP_ADD, pslot(0), S_T0, pslot(0));
         36: u = mk(OP_MUL, S_D1, S_DT, S_T0);
         37: u = mk(OP_ADD, pslot(1), S_T0, pslot(1));
         38: u = mk(OP_MUL, S_D2, S_DT, S_T0);
         39: u = mk(OP_ADD, pslot(2), S_T0, pslot(2));
         40: u = mk(OP_MUL, S_D3, S_DT, S_T0);
         41: u = mk(OP_ADD, pslot(3), S_T0, pslot(3));
         42: u = mk(OP_MUL, S_D4, S_DT, S_T0);
         43: u = mk(OP_ADD, pslot(4), S_T0, pslot(4));
         44: u = mk(OP_MUL, S_D5, S_DT, S_T0);
         45: u = mk(OP_ADD, pslot(5), S_T0, pslot(5));
         46: u = mk(OP_MUL, S_D6, S_DT, S_T0);
         47: u = mk(OP_ADD, pslot(6), S_T0, pslot(6));
         48: u = mk(OP_MUL, S_D5, S_DT, S_T0);
         49: u = mk(OP_ADD, pslot(7), S_T0, pslot(7));
         50: u = mk(OP_MUL, S_QB, S_DT, S_T0);
         51: u = mk(OP_ADD, pslot(8), S_T0, pslot(8));
         // pct -> D0..D2 ; inn -> T3
         52: u = mk(OP_MUL, S_C, pslot(0), S_D0);
         53: u = mk(OP_MUL, S_C, pslot(3), S_D1);
         54: u = mk(OP_MUL, S_C, pslot(6), S_D2);
         55: u = mk(OP_MUL, S_C, S_D0, S_T0);
         56: u = mk(OP_ADD, S_R, S_T0, S_T3);
         // 57..63: pad moves (harmless)
         // correction: k -> D3..D5, tv1/tv2 -> D6, T2 ; err -> T1
         64: u = mk(OP_DIV, S_D0, S_T3, S_D3);
         65: u = mk(OP_DIV, S_D1, S_T3, S_D4);
         66: u = mk(OP_DIV, S_D2, S_T3, S_D5);
         67: u = mk(OP_SUB, S_Z, S_POS, S_T1);
         68: u = mk(OP_MUL, S_D3, S_T1, S_T0);
         69: u = mk(OP_ADD, S_POS, S_T0, S_POS);
         70: u = mk(OP_MUL, S_D4, S_T1, S_T0);
         71: u = mk(OP_ADD, S_VEL, S_T0, S_VEL);
         72: u = mk(OP_MUL, S_D5, S_T1, S_T0);
         73: u = mk(OP_ADD, S_BIAS, S_T0, S_BIAS);
         74: u = mk(OP_MUL, S_C, pslot(1), S_D6);
         75: u = mk(OP_MUL, S_C, pslot(2), S_T2);
         // tv = {D0, D6, T2}; rows k = D3, D4, D5
         76: u = mk(OP_MUL, S_D3, S_D0, S_T0);
         77: u = mk(OP_SUB, pslot(0), S_T0, pslot(0));
         78: u = mk(OP_MUL, S_D3, S_D6, S_T0);
         79: u = mk(OP_SUB, pslot(1), S_T0, pslot(1));
         80: u = mk(OP_MUL, S_D3, S_T2, S_T0);
         81: u = mk(OP_SUB, pslot(2), S_T0, pslot(2));
         82: u = mk(OP_MUL, S_D4, S_D0, S_T0);
         83: u = mk(OP_SUB, pslot(3), S_T0, pslot(3));
         84: u = mk(OP_MUL, S_D4, S_D6, S_T0);
         85: u = mk(OP_SUB, pslot(4), S_T0, pslot(4));
         86: u = mk(OP_MUL, S_D4, S_T2, S_T0);
         87: u = mk(OP_SUB, pslot(5), S_T0, pslot(5));
         88: u = mk(OP_MUL, S_D5, S_D0, S_T0);
         89: u = mk(OP_SUB, pslot(6), S_T0, pslot(6));
         90: u = mk(OP_MUL, S_D5, S_D6, S_T0);
         91: u = mk(OP_SUB, pslot(7), S_T0, pslot(7));
         92: u = mk(OP_MUL, S_D5, S_T2, S_T0);
         93: u = mk(OP_SUB, pslot(8), S_T0, pslot(8));
         default: u = mk(OP_MOV, S_ZERO, S_ZERO, S_T0);
      endcase
      return u;
   endfunction

   localparam logic [PW-1:0] PC_CHECK = PW'(57);
   localparam logic [PW-1:0] PC_CORR  = PW'(PRED_LEN);
   localparam logic [PW-1:0] PC_END   = PW'(94);

endpackage

// ===== rtl/pvbk_alu.sv =====
// pvbk_alu: shared saturating add/sub/halve, multi-cycle multiply and divide.
// Depends on pvbk_pkg.
module pvbk_alu import pvbk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   output alu_rsp_type rsp
);

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int HW = (W + 1) / 2;          // multiplier half width
   localparam int PWID = 2 * W + 2;
   localparam int QW = W + F;                 // quotient bits
   localparam int CW = $clog2(QW + 1);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIN  = 4'b1000
   } astate_type;

   astate_type           state_ff, state_in;
   logic [W-1:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic [1:0]           step_ff, step_in;
   logic [PWID-1:0]      acc_ff, acc_in;
   logic [W:0]           rem_ff, rem_in;
   logic [QW-1:0]        num_ff, num_in;    // shifted out msb first, quotient in lsbs
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 isdiv_ff, isdiv_in;
   alu_rsp_type          rsp_ff, rsp_in;

   // combinational helpers
   logic signed [W:0]    sum;
   logic [W-1:0]         mag_a, mag_b;
   logic [HW-1:0]        pa, pb;
   logic [2*HW-1:0]      pprod;
   logic [W:0]           rtrial;
   logic [PWID-1:0]      rounded, mag_res;
   logic [W-1:0]         limit;

   function automatic logic [W-1:0] mag(input value_type v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   always_comb begin
      mag_a = mag(cmd.a);
      mag_b = mag(cmd.b);
      case (cmd.op)
         OP_SUB:  sum = {cmd.a[W-1], cmd.a} - {cmd.b[W-1], cmd.b};
         default: sum = {cmd.a[W-1], cmd.a} + {cmd.b[W-1], cmd.b};
      endcase
      // partial product select: step 0 al*bl,1 al*bh,2 ah*bl,3 ah*bh
      pa = step_ff[1] ? HW'(ma_ff >> HW) : HW'(ma_ff);
      pb = step_ff[0] ? HW'(mb_ff >> HW) : HW'(mb_ff);
      pprod = pa * pb;
      rtrial = {rem_ff[W-1:0], num_ff[QW-1]} - {1'b0, mb_ff};
      rounded = acc_ff + PWID'(64'd1 << (F - 1));
      mag_res = isdiv_ff ? PWID'(num_ff) : (rounded >> F);
      limit = W'(MAX_VAL) + W'(neg_ff);
   end

   always_comb begin
      state_in = state_ff;
      ma_in = ma_ff; mb_in = mb_ff; neg_in = neg_ff;
      step_in = step_ff; acc_in = acc_ff; rem_in = rem_ff;
      num_in = num_ff; cnt_in = cnt_ff; isdiv_in = isdiv_ff;
      rsp_in = rsp_ff;
      rsp_in.done = 1'b0;
      case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_ADD, OP_SUB: begin
                     rsp_in.done = 1'b1;
                     if (sum > $signed({MAX_VAL[W-1], MAX_VAL})) begin
                        rsp_in.result = MAX_VAL; rsp_in.sat = 1'b1;
                     end else if (sum < $signed({MIN_VAL[W-1], MIN_VAL})) begin
                        rsp_in.result = MIN_VAL; rsp_in.sat = 1'b1;
                     end else begin
                        rsp_in.result = value_type'(sum[W-1:0]); rsp_in.sat = 1'b0;
                     end
                  end
                  OP_HALF: begin
                     rsp_in.done = 1'b1;
                     rsp_in.result = cmd.a >>> 1; rsp_in.sat = 1'b0;
                  end
                  OP_MUL: begin
                     ma_in = mag_a; mb_in = mag_b;
                     neg_in = cmd.a[W-1] ^ cmd.b[W-1];
                     step_in = 2'd0; acc_in = '0; isdiv_in = 1'b0;
                     state_in = A_MUL;
                  end
                  OP_DIV: begin
                     mb_in = W'(cmd.b);
                     num_in = {mag_a, F'(0)};
                     rem_in = '0;
                     neg_in = cmd.a[W-1];
                     cnt_in = CW'(QW); isdiv_in = 1'b1;
                     state_in = A_DIV;
                  end
                  default: begin
                     rsp_in.done = 1'b1;
                     rsp_in.result = cmd.a; rsp_in.sat = 1'b0;
                  end
               endcase
            end
         end
         A_MUL: begin
            case (step_ff)
               2'd0:    acc_in = acc_ff + PWID'(pprod);
               2'd3:    acc_in = acc_ff + (PWID'(pprod) << (2 * HW));
               default: acc_in = acc_ff + (PWID'(pprod) << HW);
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = A_FIN;
         end
         A_DIV: begin
            if (!rtrial[W]) begin
               rem_in = rtrial;
               num_in = {num_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W-1:0], num_ff[QW-1]};
               num_in = {num_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) state_in = A_FIN;
         end
         A_FIN: begin
            rsp_in.done = 1'b1;
            if (mag_res > PWID'(limit)) begin
               rsp_in.sat = 1'b1;
               rsp_in.result = neg_ff ? MIN_VAL : MAX_VAL;
            end else begin
               rsp_in.sat = 1'b0;
               rsp_in.result = neg_ff ? value_type'(-mag_res[W-1:0])
                                      : value_type'(mag_res[W-1:0]);
            end
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      rsp_ff.result <= rsp_in.result;
      rsp_ff.sat <= rsp_in.sat;
      ma_ff <= ma_in; mb_ff <= mb_in; neg_ff <= neg_in; step_ff <= step_in;
      acc_ff <= acc_in; rem_ff <= rem_in; num_ff <= num_in; cnt_ff <= cnt_in;
      isdiv_ff <= isdiv_in;
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/position_velocity_bias_kalman_core.sv =====
// position_velocity_bias_kalman_core: top level, register file and micro-sequencer.
// Depends on pvbk_pkg and pvbk_alu.
//
//  channel | ports           | dir | payload
//  req     | req_valid/ready | in  | req_type: measured_position, acceleration, restart
//  rsp     | rsp_valid/ready | out | rsp_type: estimates, overflow, update_skipped
//  csr     | csr_valid/ready | in  | csr_index (3 b), csr_data (48 b)
//
// One item runs 57 prediction steps, then 30 correction steps unless the innovation
// variance is not positive, all through one shared unit: add/sub/halve answer from
// its idle state, multiply goes through issue, four partial products, saturate and
// hand-back, divide through 72 quotient bits, one a cycle. The result is offered when
// the last step is written back (or the variance check skips correction), and the
// next request is taken only after the result transfer, which rsp_ready can stall.
// Reset restores the register defaults and initial state.
// req_ready is low from acceptance until the result transfer; csr is always ready.
module position_velocity_bias_kalman_core import pvbk_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_data
);

   localparam int W = VALUE_WIDTH;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ISSUE = 5'b00010,
      S_WAIT  = 5'b00100,
      S_OUT   = 5'b01000,
      S_LOAD  = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   value_type       rf_ff [NSLOT];          // slots, each at a fixed role
   logic [PW-1:0]   pc_ff, pc_in;
   logic            ovf_ff;
   logic            req_restart_ff;
   value_type       cfg_r_ff, cfg_c_ff, cfg_iv_ff;
   rsp_type         rsp_ff;
   alu_cmd_type     cmd;
   alu_rsp_type     arsp;
   uop_type         uop;

   assign uop = prog_rom(pc_ff);

   pvbk_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp));

   always_comb begin
      cmd.start = (state_ff == S_ISSUE);
      cmd.op    = uop.op;
      cmd.a     = rf_ff[uop.sa];
      cmd.b     = rf_ff[uop.sb];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_LOAD;
         S_LOAD:  begin pc_in = '0; state_in = S_ISSUE; end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (arsp.done) begin
               pc_in = pc_ff + PW'(1);
               state_in = S_ISSUE;
               if (pc_ff + PW'(1) == PC_CHECK) begin
                  // this step writes the innovation variance
                  if (arsp.result[W-1] || arsp.result == '0)
                     state_in = S_OUT;
                  else
                     pc_in = PC_CORR;
               end else if (pc_ff + PW'(1) == PC_END) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT:   if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rf_ff[S_QP] <= value_type'(167772);
         rf_ff[S_QV] <= value_type'(3355443);
         rf_ff[S_QB] <= value_type'(754975);
         cfg_r_ff    <= value_type'(671089);
         cfg_c_ff    <= ONE_FX;
         rf_ff[S_DT] <= value_type'(83886);
         cfg_iv_ff   <= ONE_FX;
         // zero estimates, default initial variance on the diagonal
         for (int i = 0; i < 9; i++)
            rf_ff[pslot(i)] <= (i % 4 == 0) ? ONE_FX : '0;
         rf_ff[S_POS] <= '0; rf_ff[S_VEL] <= '0; rf_ff[S_BIAS] <= '0;
         rf_ff[S_ZERO] <= '0;
         pc_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         if (csr_valid) begin
            case (csr_index)
               CFG_POS_NOISE:  rf_ff[S_QP] <= value_type'({1'b0, csr_data[W-2:0]});
               CFG_VEL_NOISE:  rf_ff[S_QV] <= value_type'({1'b0, csr_data[W-2:0]});
               CFG_BIAS_NOISE: rf_ff[S_QB] <= value_type'({1'b0, csr_data[W-2:0]});
               CFG_MEAS_NOISE: cfg_r_ff    <= value_type'({1'b0, csr_data[W-2:0]});
               CFG_OBS_GAIN:   cfg_c_ff    <= value_type'(csr_data);
               CFG_TIME_STEP: begin
                  if (csr_data[FRACTION_BITS:0] > ONE_FX[FRACTION_BITS:0])
                     rf_ff[S_DT] <= ONE_FX;
                  else
                     rf_ff[S_DT] <= value_type'(csr_data[FRACTION_BITS:0]);
               end
               CFG_INIT_VAR:   cfg_iv_ff   <= value_type'({1'b0, csr_data[W-2:0]});
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_valid) begin
            rf_ff[S_Z]    <= req_data.measured_position;
            rf_ff[S_ACC]  <= req_data.acceleration;
            rf_ff[S_ZERO] <= '0;
            rf_ff[S_R]    <= cfg_r_ff;
            rf_ff[S_C]    <= cfg_c_ff;
            req_restart_ff <= req_data.restart;
            ovf_ff  <= 1'b0;
         end
         // restart: reload estimates and covariance before the step
         if (state_ff == S_LOAD && req_restart_ff) begin
            for (int i = 0; i < 9; i++)
               rf_ff[pslot(i)] <= (i % 4 == 0) ? cfg_iv_ff : '0;
            rf_ff[S_POS] <= '0; rf_ff[S_VEL] <= '0; rf_ff[S_BIAS] <= '0;
         end
         if (state_ff == S_WAIT && arsp.done) begin
            rf_ff[uop.dst] <= arsp.result;
            if (arsp.sat) ovf_ff <= 1'b1;
         end
         if (state_ff == S_WAIT && state_in == S_OUT) begin
            rsp_ff.position_estimate <= rf_ff[S_POS];
            rsp_ff.velocity_estimate <= rf_ff[S_VEL];
            rsp_ff.bias_estimate     <= (uop.dst == S_BIAS) ? arsp.result : rf_ff[S_BIAS];
            rsp_ff.overflow          <= ovf_ff | arsp.sat;
            rsp_ff.update_skipped    <= (pc_ff + PW'(1) == PC_CHECK);
         end
      end
   end

   // no new request taken while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request accepted with result pending");
   // a result transfer returns the core to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("core not idle after result transfer");
   // the shared unit is never started back to back
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !cmd.start)
      else $error("back-to-back unit start");

endmodule
